// File: rtl/lps_pkg.sv
package lps_pkg;

   localparam int LED_COUNT   = 3;
   localparam int MODE_COUNT  = 6;
   localparam int TABLE_MODES = 6;
   localparam int HOLD_TICKS  = 500 / 10;
   localparam int HOLD_W      = $clog2(HOLD_TICKS + 1);
   localparam int MODE_W      = 3;
   localparam int FLAGS_W     = 6;

   // csr map
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic REG_REPEAT_FLAGS = 1'b0;
   localparam logic [FLAGS_W-1:0] FLAGS_RESET = '1;

   typedef logic [LED_COUNT-1:0] led_type;
   typedef logic [MODE_W-1:0]    mode_type;
   typedef logic [HOLD_W-1:0]    hold_type;
   typedef logic [FLAGS_W-1:0]   flags_type;

   localparam mode_type MODE_NONE  = mode_type'(MODE_COUNT);
   localparam mode_type MODE_READY = mode_type'(0);
   localparam mode_type MODE_ERROR = mode_type'(1);
   localparam mode_type MODE_BUSY  = mode_type'(2);
   localparam mode_type MODE_OK    = mode_type'(3);
   localparam mode_type MODE_FAIL  = mode_type'(4);
   localparam mode_type MODE_OFF   = mode_type'(5);

   localparam hold_type HOLD_BLINK = hold_type'(HOLD_TICKS);

   typedef enum logic {
      ACT_TICK = 1'b0,
      ACT_PLAY = 1'b1
   } action_type;

   typedef struct packed {
      action_type action;
      mode_type   mode;
   } item_type;

   typedef struct packed {
      led_type  led_bits;
      mode_type active_mode;
      logic     timer_running;
   } result_type;

   typedef struct packed {
      logic     two_steps;
      led_type  mask;
      led_type  on;
      hold_type hold;
   } step_type;

   // pattern rom, modes without an entry turn all leds off with no hold
   function automatic step_type pattern_step(mode_type mode, logic step_sel);
      step_type r;
      r = '{two_steps: 1'b0, mask: '1, on: '0, hold: '0};
      unique case (mode)
         MODE_READY: r = '{1'b0, led_type'(3'h4), led_type'(3'h0), hold_type'(0)};
         MODE_ERROR: begin
            if (step_sel) begin
               r = '{1'b1, led_type'(3'h2), led_type'(3'h2), HOLD_BLINK};
            end else begin
               r = '{1'b1, led_type'(3'h7), led_type'(3'h0), HOLD_BLINK};
            end
         end
         MODE_BUSY:  r = '{1'b0, led_type'(3'h7), led_type'(3'h4), hold_type'(0)};
         MODE_OK:    r = '{1'b0, led_type'(3'h7), led_type'(3'h1), hold_type'(0)};
         MODE_FAIL:  r = '{1'b0, led_type'(3'h7), led_type'(3'h2), hold_type'(0)};
         MODE_OFF:   r = '{1'b0, led_type'(3'h7), led_type'(3'h0), hold_type'(0)};
         default:    r = '{two_steps: 1'b0, mask: '1, on: '0, hold: '0};
      endcase
      // second step of a one-step mode is never applied
      if (step_sel && !r.two_steps) begin
         r.mask = '0;
         r.on   = '0;
         r.hold = '0;
      end
      return r;
   endfunction

   function automatic logic mode_repeats(mode_type mode, flags_type flags);
      logic rep;
      rep = 1'b0;
      for (int i = 0; i < TABLE_MODES; i++) begin
         if (mode == mode_type'(i)) begin
            rep = flags[i];
         end
      end
      return rep;
   endfunction

endpackage

// File: rtl/lps_csr.sv
module lps_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [lps_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [lps_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [lps_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                              pready,
   output lps_pkg::flags_type                repeat_flags
);
   import lps_pkg::*;

   flags_type flags_ff, flags_in;
   logic      reg_sel;

   assign reg_sel = (paddr[CSR_ADDR_W-1:2] == REG_REPEAT_FLAGS);

   always_comb begin
      flags_in = flags_ff;
      if (psel && penable && pwrite && reg_sel) begin
         flags_in = pwdata[FLAGS_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff <= FLAGS_RESET;
      end else begin
         flags_ff <= flags_in;
      end
   end

   assign pready       = 1'b1;
   assign prdata       = reg_sel ? CSR_DATA_W'(flags_ff) : '0;
   assign repeat_flags = flags_ff;

endmodule

// File: rtl/lps_core.sv
module lps_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                item_valid,
   input  lps_pkg::item_type   item,
   input  lps_pkg::flags_type  repeat_flags,
   output lps_pkg::result_type result
);
   import lps_pkg::*;

   led_type  led_ff, led_in;
   mode_type cur_ff, cur_in;
   mode_type rem_ff, rem_in;
   logic     step_ff, step_in;
   hold_type cnt_ff, cnt_in;
   logic     active_ff, active_in;

   hold_type cnt_dec;
   logic     do_apply;
   mode_type tgt_mode;
   logic     tgt_step;
   step_type cur_pat;
   step_type tgt_pat;
   logic     cur_rep;

   assign cnt_dec = cnt_ff - hold_type'(1);
   assign cur_pat = pattern_step(cur_ff, 1'b0);
   assign cur_rep = mode_repeats(cur_ff, repeat_flags);
   assign tgt_pat = pattern_step(tgt_mode, tgt_step);

   always_comb begin
      led_in    = led_ff;
      cur_in    = cur_ff;
      rem_in    = rem_ff;
      step_in   = step_ff;
      cnt_in    = cnt_ff;
      active_in = active_ff;
      do_apply  = 1'b0;
      tgt_mode  = cur_ff;
      tgt_step  = 1'b0;
      if (item_valid) begin
         if (item.action == ACT_PLAY) begin
            if (item.mode < mode_type'(MODE_COUNT) && item.mode != cur_ff) begin
               if (cur_ff < mode_type'(MODE_COUNT) && cur_rep) begin
                  rem_in = cur_ff;
               end
               cur_in   = item.mode;
               step_in  = 1'b0;
               do_apply = 1'b1;
               tgt_mode = item.mode;
            end
         end else if (active_ff) begin
            cnt_in = cnt_dec;
            if (cnt_dec == '0) begin
               // hold expired: next step, repeat, fall back to the remembered mode, or stop
               if (!step_ff && cur_pat.two_steps) begin
                  step_in  = 1'b1;
                  do_apply = 1'b1;
                  tgt_step = 1'b1;
               end else begin
                  step_in = 1'b0;
                  if (cur_rep) begin
                     do_apply = 1'b1;
                  end else if (rem_ff >= mode_type'(MODE_COUNT)) begin
                     active_in = 1'b0;
                     cnt_in    = '0;
                  end else begin
                     cur_in   = rem_ff;
                     tgt_mode = rem_ff;
                     do_apply = 1'b1;
                  end
               end
            end
         end
      end
      if (do_apply) begin
         led_in    = (led_ff & ~tgt_pat.mask) | (tgt_pat.on & tgt_pat.mask);
         cnt_in    = tgt_pat.hold;
         active_in = (tgt_pat.hold != '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         led_ff    <= '0;
         cur_ff    <= MODE_NONE;
         rem_ff    <= MODE_NONE;
         step_ff   <= 1'b0;
         cnt_ff    <= '0;
         active_ff <= 1'b0;
      end else begin
         led_ff    <= led_in;
         cur_ff    <= cur_in;
         rem_ff    <= rem_in;
         step_ff   <= step_in;
         cnt_ff    <= cnt_in;
         active_ff <= active_in;
      end
   end

   assign result.led_bits      = led_in;
   assign result.active_mode   = cur_in;
   assign result.timer_running = active_in;

   // a running countdown never sits at zero
   a_active_cnt : assert property (@(posedge clock) disable iff (reset)
      active_ff |-> (cnt_ff != '0))
      else $error("countdown running at zero");

   // no countdown without a mode
   a_none_idle : assert property (@(posedge clock) disable iff (reset)
      (cur_ff == MODE_NONE) |-> !active_ff)
      else $error("countdown running with no mode");

   // an idle tick leaves the whole state alone
   a_idle_tick : assert property (@(posedge clock) disable iff (reset)
      (item_valid && item.action == ACT_TICK && !active_ff)
      |=> ($stable(led_ff) && $stable(cur_ff) && $stable(rem_ff) && $stable(cnt_ff)))
      else $error("idle tick changed state");

endmodule

// File: rtl/led_pattern_sequencer_unit.sv
// LED pattern sequencer. Each request word either plays one of six built-in
// modes (ready, error, busy, ok, fail, off) or delivers one 10 ms tick; each
// word produces exactly one response word carrying the LED levels, the mode
// now playing (6 = none) and whether a step hold countdown is running. A play
// request for an out-of-range mode or the mode already playing changes
// nothing. A repeating mode is remembered when another one takes over, and a
// non-repeating mode falls back to it once its steps run out. Throughput is
// one word per clock while rsp_stall is low: a word is held in the request
// register, the whole state update is made from it and lands in the response
// register, and a new word is taken while the last one is still held there.
// The response register decouples the channels; rsp_stall only backs up into
// req_stall once both registers are full. repeat_flags (byte address 0,
// reset all ones) selects which modes repeat and may only be written while
// no word is in flight.
module led_pattern_sequencer_unit (
   input  logic                           clock,
   input  logic                           reset,
   // request channel
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic                           req_action,
   input  logic [2:0]                     req_mode_request,
   // response channel
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [2:0]                     rsp_led_bits,
   output logic [2:0]                     rsp_active_mode,
   output logic                           rsp_timer_running,
   // register port
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [lps_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [lps_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [lps_pkg::CSR_DATA_W-1:0] prdata,
   output logic                           pready
);
   import lps_pkg::*;

   // request register
   logic       in_valid_ff, in_valid_in;
   item_type   in_item_ff, in_item_in;

   // response register
   logic       out_valid_ff, out_valid_in;
   result_type out_res_ff, out_res_in;

   logic       out_free;
   logic       in_adv;
   logic       accept;
   flags_type  repeat_flags;
   result_type core_res;

   lps_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .psel         (psel),
      .penable      (penable),
      .pwrite       (pwrite),
      .paddr        (paddr),
      .pwdata       (pwdata),
      .prdata       (prdata),
      .pready       (pready),
      .repeat_flags (repeat_flags)
   );

   lps_core u_core (
      .clock        (clock),
      .reset        (reset),
      .item_valid   (in_adv),
      .item         (in_item_ff),
      .repeat_flags (repeat_flags),
      .result       (core_res)
   );

   // handshake: the response register frees up when empty or being drained
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign in_adv    = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_item_in  = in_item_ff;
      if (accept) begin
         in_valid_in       = 1'b1;
         in_item_in.action = action_type'(req_action);
         in_item_in.mode   = req_mode_request;
      end else if (in_adv) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_res_in   = out_res_ff;
      if (in_adv) begin
         out_valid_in = 1'b1;
         out_res_in   = core_res;
      end else if (out_free) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload, no reset needed
   always_ff @(posedge clock) begin
      in_item_ff <= in_item_in;
      out_res_ff <= out_res_in;
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_led_bits      = out_res_ff.led_bits;
   assign rsp_active_mode   = out_res_ff.active_mode;
   assign rsp_timer_running = out_res_ff.timer_running;

endmodule
